// ===== hdl/rmts_pkg.sv =====
`default_nettype none

package rmts_pkg;

   // Item codes carried in the mode field
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam int CFG_BITS = 4;

   typedef struct packed {
      logic        mode;
      logic [2:0]  task_slot;
      logic [15:0] exec_time;
      logic [15:0] task_period;
   } req_type;

   typedef struct packed {
      logic       ran;
      logic [2:0] run_slot;
      logic [7:0] miss_mask;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/rmts_pick.sv =====
`default_nettype none

// Shortest-period pick over the ready tasks; ties go to the lower index.
module rmts_pick import rmts_pkg::*; #(
   parameter int SLOTS     = 8,
   parameter int TIME_BITS = 16
) (
   input  wire logic                     ready   [SLOTS],
   input  wire logic [TIME_BITS-1:0]     period  [SLOTS],
   output logic                          found,
   output logic [$clog2(SLOTS)-1:0]      pick_idx
);

   localparam int LEVELS = $clog2(SLOTS);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = 2 * LEAVES;

   logic                 node_vld [1:NODES-1];
   logic [TIME_BITS-1:0] node_per [1:NODES-1];
   logic [LEVELS-1:0]    node_idx [1:NODES-1];

   for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
      localparam int LI = l;
      if (l < SLOTS) begin : g_used
         assign node_vld[LEAVES+l] = ready[l];
         assign node_per[LEAVES+l] = period[l];
      end else begin : g_pad
         assign node_vld[LEAVES+l] = 1'b0;
         assign node_per[LEAVES+l] = '0;
      end
      assign node_idx[LEAVES+l] = LI[LEVELS-1:0];
   end

   // Left child holds lower indices, so it wins on equal periods
   for (genvar n = 1; n < LEAVES; n++) begin : g_node
      logic take_left;
      assign take_left = node_vld[2*n] &&
                         (!node_vld[2*n+1] || (node_per[2*n] <= node_per[2*n+1]));
      assign node_vld[n] = node_vld[2*n] || node_vld[2*n+1];
      assign node_per[n] = take_left ? node_per[2*n] : node_per[2*n+1];
      assign node_idx[n] = take_left ? node_idx[2*n] : node_idx[2*n+1];
   end

   assign found    = node_vld[1];
   assign pick_idx = node_idx[1];

endmodule

`default_nettype wire

// ===== hdl/rate_monotonic_tick_scheduler_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      req_item  (rmts_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready      rsp_item  (rmts_pkg::rsp_type)
// csr       in         csr_wr_en, no wait         csr_wr_data (task_count, 4 bits)
//
// Each item runs through the release, countdown and pick logic that sits between
// the task table registers and the result register, and one item is accepted
// per cycle whenever the result register is empty or being drained.
// A stalled result holds req_ready low until it is taken.
// Synchronous reset clears the task table to its idle values (period one,
// everything else zero) and sets task_count to one; no sweep is needed.
module rate_monotonic_tick_scheduler_core import rmts_pkg::*; #(
   parameter int TASK_SLOTS = 8,
   parameter int TIME_BITS  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_item,
   input  wire logic                csr_wr_en,
   input  wire logic [CFG_BITS-1:0] csr_wr_data
);

   localparam int SLOT_BITS = $clog2(TASK_SLOTS);
   localparam int MISS_W    = (TASK_SLOTS > 8) ? TASK_SLOTS : 8;
   localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

   // Task table
   logic [TIME_BITS-1:0] exec_ff   [TASK_SLOTS];
   logic [TIME_BITS-1:0] period_ff [TASK_SLOTS];
   logic [TIME_BITS-1:0] work_ff   [TASK_SLOTS];
   logic [TIME_BITS-1:0] cd_ff     [TASK_SLOTS];
   logic [TIME_BITS-1:0] exec_in   [TASK_SLOTS];
   logic [TIME_BITS-1:0] period_in [TASK_SLOTS];
   logic [TIME_BITS-1:0] work_in   [TASK_SLOTS];
   logic [TIME_BITS-1:0] cd_in     [TASK_SLOTS];

   logic [CFG_BITS-1:0]  task_count_ff;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                 req_fire;

   // Tick view of each entry after the release step
   logic [5:0]           act_cnt;
   logic                 active    [TASK_SLOTS];
   logic                 released  [TASK_SLOTS];
   logic                 ready_vec [TASK_SLOTS];
   logic [TIME_BITS-1:0] work_rel  [TASK_SLOTS];
   logic [MISS_W-1:0]    miss_vec;

   logic                 pick_found;
   logic [SLOT_BITS-1:0] pick_idx;

   // Load decode
   logic [31:0]          slot_wide;
   logic [31:0]          exec_wide;
   logic [31:0]          per_wide;
   logic [SLOT_BITS-1:0] load_idx;
   logic                 load_ok;
   logic [TIME_BITS-1:0] load_exec;
   logic [TIME_BITS-1:0] load_per;
   logic [31:0]          pick_wide;

   // Accept while the result register is free or its item leaves this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Clamp the active count to 1 .. TASK_SLOTS
   always_comb begin
      if (task_count_ff == '0) begin
         act_cnt = 6'd1;
      end else if ({2'b00, task_count_ff} > 6'(TASK_SLOTS)) begin
         act_cnt = 6'(TASK_SLOTS);
      end else begin
         act_cnt = {2'b00, task_count_ff};
      end
   end

   // Release step: a zero countdown reloads the work, flagging leftover work
   always_comb begin
      miss_vec = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         active[i]   = 6'(i) < act_cnt;
         released[i] = active[i] && (cd_ff[i] == '0);
         work_rel[i] = released[i] ? exec_ff[i] : work_ff[i];
         miss_vec[i] = released[i] && (work_ff[i] != '0);
         ready_vec[i] = active[i] && (work_rel[i] != '0);
      end
   end

   rmts_pick #(
      .SLOTS     (TASK_SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_pick (
      .ready    (ready_vec),
      .period   (period_ff),
      .found    (pick_found),
      .pick_idx (pick_idx)
   );

   always_comb begin
      slot_wide = 32'(req_item.task_slot);
      exec_wide = 32'(req_item.exec_time);
      per_wide  = 32'(req_item.task_period);
      load_idx  = slot_wide[SLOT_BITS-1:0];
      load_ok   = slot_wide < 32'(TASK_SLOTS);
      load_exec = exec_wide[TIME_BITS-1:0];
      load_per  = per_wide[TIME_BITS-1:0];
      // A zero period is stored as one
      if (load_per == '0) begin
         load_per = TIME_ONE;
      end
      pick_wide = 32'(pick_idx);
   end

   // Next state of the table and the result of this item
   always_comb begin
      exec_in   = exec_ff;
      period_in = period_ff;
      work_in   = work_ff;
      cd_in     = cd_ff;
      rsp_in    = '0;
      if (req_fire) begin
         if (req_item.mode == MODE_LOAD) begin
            // Out-of-range slots drop the write but still answer
            if (load_ok) begin
               exec_in[load_idx]   = load_exec;
               period_in[load_idx] = load_per;
               work_in[load_idx]   = '0;
               cd_in[load_idx]     = '0;
            end
         end else begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               work_in[i] = work_rel[i];
               if (released[i]) begin
                  cd_in[i] = period_ff[i] - TIME_ONE;
               end else if (active[i]) begin
                  cd_in[i] = cd_ff[i] - TIME_ONE;
               end
            end
            if (pick_found) begin
               work_in[pick_idx] = work_rel[pick_idx] - TIME_ONE;
            end
            rsp_in.ran       = pick_found;
            rsp_in.run_slot  = pick_found ? pick_wide[2:0] : 3'd0;
            rsp_in.miss_mask = miss_vec[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            exec_ff[i]   <= '0;
            period_ff[i] <= TIME_ONE;
            work_ff[i]   <= '0;
            cd_ff[i]     <= '0;
         end
         task_count_ff <= CFG_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         exec_ff   <= exec_in;
         period_ff <= period_in;
         work_ff   <= work_in;
         cd_ff     <= cd_in;
         if (csr_wr_en) begin
            task_count_ff <= csr_wr_data;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rmts_checker.sv =====
`default_nettype none

module rmts_checker import rmts_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire req_type             req_item,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire rsp_type             rsp_item
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // Every accepted item shows a result in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   // A load answers all zeros
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.mode == MODE_LOAD) |=> rsp_item == '0)
      else $error("load result not zero");

   // Idle ticks report slot zero
   a_idle_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.ran |-> rsp_item.run_slot == 3'd0)
      else $error("idle result with nonzero slot");

   // Intake stops while a result is stalled
   a_back_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted over a stalled result");

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker u_rmts_checker (.*);

`default_nettype wire

// ===== tb/tb_rate_monotonic_tick_scheduler_core.sv =====
`default_nettype none

module tb_rate_monotonic_tick_scheduler_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rmts_pkg::*;

   localparam int TASK_SLOTS = 8;
   localparam int TIME_BITS  = 16;
   localparam int CLK_PERIOD = 10;
   localparam int PHASES     = 8;
   localparam int RAND_ITEMS = 60;
   localparam int HOLD_OFF   = 80;

   // A directed row either writes task_count (after a drain) or offers one item
   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [CFG_BITS-1:0] cfg;
      req_type             item;
      bit                  typed;
      rsp_type             outcome;
   } stim_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_item    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_item;
   logic                csr_wr_en   = 1'b0;
   logic [CFG_BITS-1:0] csr_wr_data = '0;

   // Own copy of the task table, kept in step with every accepted item
   logic [TIME_BITS-1:0] mdl_budget    [TASK_SLOTS];
   logic [TIME_BITS-1:0] mdl_period    [TASK_SLOTS];
   logic [TIME_BITS-1:0] mdl_work      [TASK_SLOTS];
   logic [TIME_BITS-1:0] mdl_countdown [TASK_SLOTS];
   logic [CFG_BITS-1:0]  mdl_task_count;

   rsp_type      pending_outcomes [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;

   // Traffic shaping, changed per phase by the stimulus process
   bit gaps_on      = 1'b1;
   bit stalls_on    = 1'b1;
   bit quiet_tail   = 1'b0;
   bit hold_off_req = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   rate_monotonic_tick_scheduler_core #(
      .TASK_SLOTS (TASK_SLOTS),
      .TIME_BITS  (TIME_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Apply one item to the task table copy and return the outcome it must give.
   // Releases come first, then the shortest-period ready task runs one unit.
   function automatic rsp_type schedule_item(input req_type it);
      rsp_type              r;
      int                   n;
      int                   pick;
      bit                   found;
      logic [TIME_BITS-1:0] pick_period;
      r = '0;
      if (it.mode == MODE_LOAD) begin
         mdl_budget[it.task_slot]    = it.exec_time;
         mdl_period[it.task_slot]    = (it.task_period == '0) ? 16'd1 : it.task_period;
         mdl_work[it.task_slot]      = '0;
         mdl_countdown[it.task_slot] = '0;
         return r;
      end
      n = (mdl_task_count == 0) ? 1 :
          (mdl_task_count > TASK_SLOTS) ? TASK_SLOTS : int'(mdl_task_count);
      for (int i = 0; i < n; i++) begin
         if (mdl_countdown[i] == '0) begin
            if (mdl_work[i] != '0) r.miss_mask[i] = 1'b1;
            mdl_work[i]      = mdl_budget[i];
            mdl_countdown[i] = mdl_period[i] - 1'b1;
         end else begin
            mdl_countdown[i] = mdl_countdown[i] - 1'b1;
         end
      end
      found       = 1'b0;
      pick        = 0;
      pick_period = '0;
      for (int i = 0; i < n; i++) begin
         if (mdl_work[i] != '0 && (!found || mdl_period[i] < pick_period)) begin
            found       = 1'b1;
            pick        = i;
            pick_period = mdl_period[i];
         end
      end
      if (found) begin
         mdl_work[pick] = mdl_work[pick] - 1'b1;
         r.ran          = 1'b1;
         r.run_slot     = pick[2:0];
      end
      return r;
   endfunction

   // Directed table builders: loads always answer all zeros, ticks only
   // carry a typed outcome where it is obvious
   function automatic void load_row(input int slot, input int budget, input int period);
      stim_row_type row;
      row.kind                  = ROW_ITEM;
      row.cfg                   = '0;
      row.item.mode             = MODE_LOAD;
      row.item.task_slot        = 3'(slot);
      row.item.exec_time        = 16'(budget);
      row.item.task_period      = 16'(period);
      row.typed                 = 1'b1;
      row.outcome               = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void tick_row(input bit typed, input bit ran, input int slot,
                                    input int misses);
      stim_row_type row;
      row.kind                  = ROW_ITEM;
      row.cfg                   = '0;
      row.item.mode             = MODE_TICK;
      row.item.task_slot        = 3'(directed_rows.size());
      row.item.exec_time        = 16'hA5A5;
      row.item.task_period      = 16'h5A5A;
      row.typed                 = typed;
      row.outcome.ran           = ran;
      row.outcome.run_slot      = 3'(slot);
      row.outcome.miss_mask     = 8'(misses);
      directed_rows.push_back(row);
   endfunction

   function automatic void cfg_row(input int value);
      stim_row_type row;
      row         = '{default: '0, kind: ROW_CFG, item: '0, outcome: '0};
      row.cfg     = CFG_BITS'(value);
      directed_rows.push_back(row);
   endfunction

   // Load with a sensible budget for a task that should actually get run
   function automatic req_type sensible_load(input int slot);
      req_type it;
      it.mode        = MODE_LOAD;
      it.task_slot   = 3'(slot);
      it.task_period = 16'($urandom_range(1, 20));
      it.exec_time   = 16'($urandom_range(0, it.task_period));
      return it;
   endfunction

   // Mostly ticks with junk in the unused fields; now and then a load, usually
   // small but sometimes with full-range or zero values
   function automatic req_type random_item();
      req_type it;
      it.mode        = MODE_TICK;
      it.task_slot   = 3'($urandom);
      it.exec_time   = 16'($urandom);
      it.task_period = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         it.mode = MODE_LOAD;
         if ($urandom_range(0, 4) != 0) begin
            it.task_period = 16'($urandom_range(0, 24));
            it.exec_time   = 16'($urandom_range(0, 6));
         end
      end
      return it;
   endfunction

   // Offer one item, hold it until taken, then record what it must produce.
   // Valid stays high across back-to-back items unless a gap is drawn.
   task automatic offer_item(input req_type it, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      predicted = schedule_item(it);
      pending_outcomes.push_back(typed ? typed_rsp : predicted);
      if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Drain everything in flight, then write task_count while the block is idle
   task automatic write_task_count(input logic [CFG_BITS-1:0] value);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      mdl_task_count = value;
      csr_wr_en <= 1'b0;
   endtask

   // Result side: random ready bursts, one long hold-off on request, and a
   // steady ready in the quiet tail
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            // hold ready low long enough for the block to back up into req_ready
            rsp_ready <= 1'b0;
            for (int c = 0; c < HOLD_OFF; c++) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (stalls_on && !quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Compare each result taken with the oldest outstanding expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with no item outstanding", rsp_item, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_item.ran !== want.ran)
               report_mismatch("ran", rsp_item.ran, want.ran);
            if (rsp_item.run_slot !== want.run_slot)
               report_mismatch("run_slot", rsp_item.run_slot, want.run_slot);
            if (rsp_item.miss_mask !== want.miss_mask)
               report_mismatch("miss_mask", rsp_item.miss_mask, want.miss_mask);
         end
      end
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int                  active;
      logic [CFG_BITS-1:0] cfg_val;
      req_type             it;

      // Start the table copy from its reset values
      mdl_task_count = 1;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         mdl_budget[i]    = '0;
         mdl_period[i]    = 16'd1;
         mdl_work[i]      = '0;
         mdl_countdown[i] = '0;
      end

      // First tick after reset: task 0 is released with no budget, so idle
      tick_row(1'b1, 1'b0, 0, 8'h00);
      // Zero period is stored as one, so task 0 is released every tick
      load_row(0, 2, 0);
      tick_row(1'b1, 1'b1, 0, 8'h00);
      // Release finds one unit still left: flag the miss on task 0
      tick_row(1'b1, 1'b1, 0, 8'h01);
      cfg_row(8);
      // Extremes of budget and period, plus two equal periods to test the tie
      load_row(7, 16'hFFFF, 16'hFFFF);
      load_row(3, 1, 3);
      load_row(5, 1, 3);
      load_row(6, 2, 1);
      load_row(1, 0, 16'hFFFF);
      repeat (5) tick_row(1'b0, 1'b0, 0, 0);
      // Count of zero acts as one: upper entries hold their countdowns
      cfg_row(0);
      repeat (2) tick_row(1'b0, 1'b0, 0, 0);
      // Count above the table size acts as the full table
      cfg_row(15);
      load_row(2, 16'h8000, 1);
      repeat (4) tick_row(1'b0, 1'b0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CFG)
            write_task_count(directed_rows[r].cfg);
         else
            offer_item(directed_rows[r].item, directed_rows[r].typed,
                       directed_rows[r].outcome);
      end

      // Random phases: new task_count, a well-formed load of every active
      // entry, then a run of mostly ticks with the odd stray load
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: cfg_val = 4'd8;
            1: cfg_val = 4'd1;
            2: cfg_val = 4'd0;
            3: cfg_val = 4'd15;
            4: cfg_val = 4'd5;
            5: cfg_val = CFG_BITS'($urandom);
            6: cfg_val = 4'd3;
            default: cfg_val = 4'd8;
         endcase
         write_task_count(cfg_val);
         gaps_on    = (phase % 3) != 1;
         stalls_on  = (phase % 4) != 2;
         quiet_tail = (phase == PHASES - 1);
         active = (cfg_val == 0) ? 1 : (cfg_val > TASK_SLOTS) ? TASK_SLOTS : int'(cfg_val);
         for (int s = 0; s < active; s++)
            offer_item(sensible_load(s), 1'b0, '0);
         if (phase == 2) begin
            // keep offering with no gaps while the result side holds off
            gaps_on      = 1'b0;
            hold_off_req = 1'b1;
         end
         for (int k = 0; k < RAND_ITEMS; k++) begin
            it = random_item();
            offer_item(it, 1'b0, '0);
         end
      end

      // Drop valid, wait for the last results, then allow for stray extras
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/rmts_pkg.sv
hdl/rmts_pick.sv
hdl/rate_monotonic_tick_scheduler_core.sv
hdl/rmts_checker.sv
tb/tb_rate_monotonic_tick_scheduler_core.sv
